// File: rtl/core/acrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acrs_pkg: shared types and constants for the sound control block
// Word formats, action codes, register addresses and the reset image of the
// register file.
// ----------------------------------------------------------------------------
package acrs_pkg;

  typedef enum logic [1:0] {
    ActRead   = 2'd0,
    ActWrite  = 2'd1,
    ActTick   = 2'd2,
    ActIgnore = 2'd3
  } action_e;

  typedef struct packed {
    action_e    action;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] div_value;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       unmapped;
    logic [3:0] channels_on;
  } out_word_t;

  localparam int unsigned RegDepth = 23;
  localparam int unsigned IdxW     = 5;

  localparam logic [7:0] AddrBase = 8'h10;
  localparam logic [7:0] AddrNr10 = 8'h10;
  localparam logic [7:0] AddrNr11 = 8'h11;
  localparam logic [7:0] AddrNr12 = 8'h12;
  localparam logic [7:0] AddrNr13 = 8'h13;
  localparam logic [7:0] AddrNr14 = 8'h14;
  localparam logic [7:0] AddrNr21 = 8'h16;
  localparam logic [7:0] AddrNr22 = 8'h17;
  localparam logic [7:0] AddrNr23 = 8'h18;
  localparam logic [7:0] AddrNr24 = 8'h19;
  localparam logic [7:0] AddrNr30 = 8'h1A;
  localparam logic [7:0] AddrNr31 = 8'h1B;
  localparam logic [7:0] AddrNr32 = 8'h1C;
  localparam logic [7:0] AddrNr33 = 8'h1D;
  localparam logic [7:0] AddrNr34 = 8'h1E;
  localparam logic [7:0] AddrNr41 = 8'h20;
  localparam logic [7:0] AddrNr42 = 8'h21;
  localparam logic [7:0] AddrNr43 = 8'h22;
  localparam logic [7:0] AddrNr44 = 8'h23;
  localparam logic [7:0] AddrNr50 = 8'h24;
  localparam logic [7:0] AddrNr51 = 8'h25;
  localparam logic [7:0] AddrNr52 = 8'h26;

  localparam logic [7:0] MaskNone  = 8'h00;
  localparam logic [7:0] MaskDuty  = 8'h3F;
  localparam logic [7:0] MaskCtrl  = 8'hBF;
  localparam logic [7:0] MaskTrig  = 8'h38;
  localparam logic [7:0] MaskDac   = 8'h7F;
  localparam logic [7:0] MaskLevel = 8'h9F;
  localparam logic [7:0] MaskLen4  = 8'hC0;
  localparam logic [7:0] MaskSwp   = 8'h80;
  localparam logic [7:0] ReadOpen  = 8'hFF;
  localparam logic [10:0] PeriodMax = 11'd2047;

  // Reset image, indexed by address minus the base.
  function automatic logic [7:0] reg_init(input logic [IdxW-1:0] idx);
    logic [7:0] v;
    case (idx)
      5'd0:    v = 8'h80;
      5'd1:    v = 8'hBF;
      5'd2:    v = 8'hF3;
      5'd4:    v = 8'hBF;
      5'd6:    v = 8'h3F;
      5'd7:    v = 8'h00;
      5'd9:    v = 8'hBF;
      5'd10:   v = 8'h7F;
      5'd12:   v = 8'h9F;
      5'd14:   v = 8'hBF;
      5'd17:   v = 8'h00;
      5'd18:   v = 8'h00;
      5'd19:   v = 8'hBF;
      5'd20:   v = 8'h77;
      5'd21:   v = 8'hF3;
      5'd22:   v = 8'hF1;
      default: v = 8'hFF;
    endcase
    return v;
  endfunction

  // Next sweep period; bit 11 flags overflow.
  function automatic logic [11:0] sweep_next(input logic [10:0] period,
                                             input logic [2:0]  shift,
                                             input logic        negate);
    logic [11:0] d;
    d = {1'b0, period >> shift};
    return negate ? ({1'b0, period} - d) : ({1'b0, period} + d);
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/audio_control_registers_and_sequencer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// audio_control_registers_and_sequencer_top: sound control registers
// Register file in a 23-byte synchronous memory, channel control in flops,
// 8-step frame sequencer for lengths, sweep and envelopes.
//
//   port group   dir  payload             handshake
//   in_word_i    in   acrs_pkg::in_word_t in_valid_i / in_stall_o
//   out_word_o   out  acrs_pkg::out_word_t out_valid_o / out_stall_i
//
// One word per cycle while the output is not stalled; each word yields one result word
// in the next cycle, from the registered memory read.
// Reset is asynchronous; memory entries carry valid bits and read as their
// reset image until first written.
// A stalled output holds the input stall high; no skid stage.
// ----------------------------------------------------------------------------
module audio_control_registers_and_sequencer_top (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire acrs_pkg::in_word_t in_word_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output acrs_pkg::out_word_t out_word_o
);

  logic [7:0] mem_q [acrs_pkg::RegDepth];
  logic [acrs_pkg::RegDepth-1:0] mvld_q;
  logic [7:0] mdata_q;
  logic       mdvld_q;

  logic       accept;
  logic [7:0] addr_off;
  logic [acrs_pkg::IdxW-1:0] idx;
  logic       mem_we;
  logic [7:0] mem_wdata;

  logic [6:0]  nr10_q, nr10_d;
  logic [7:0]  nrx2_q [3];
  logic [7:0]  nrx2_d [3];
  logic [3:0]  len_en_q, len_en_d;
  logic [10:0] freq_q, freq_d;
  logic        power_q, power_d;
  logic [3:0]  ch_q, ch_d;
  logic [6:0]  len_q [3];
  logic [6:0]  len_d [3];
  logic [8:0]  lenw_q, lenw_d;
  logic [3:0]  vol_q [3];
  logic [3:0]  vol_d [3];
  logic [2:0]  ecd_q [3];
  logic [2:0]  ecd_d [3];
  logic [10:0] swp_q, swp_d;
  logic [3:0]  scd_q, scd_d;
  logic        sact_q, sact_d;
  logic [2:0]  seq_q, seq_d;
  logic        prev_q, prev_d;
  logic [3:0]  trig;

  logic        out_valid_q;
  logic        use_mem_q, use_mem_d;
  logic [7:0]  mask_q, mask_d;
  logic [7:0]  const_q, const_d;
  logic [acrs_pkg::IdxW-1:0] idx_q;
  logic        unm_q, unm_d;
  logic [3:0]  chout_q;

  logic [11:0] trig_next;
  logic [11:0] tick_next;
  logic [3:0]  pace_reload;
  logic [3:0]  scd_dec;
  logic [2:0]  ecd_dec;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign addr_off   = in_word_i.reg_addr - acrs_pkg::AddrBase;
  assign idx        = addr_off[acrs_pkg::IdxW-1:0];
  assign pace_reload = (nr10_q[6:4] != 3'd0) ? {1'b0, nr10_q[6:4]} : 4'd8;
  assign trig_next  = acrs_pkg::sweep_next({in_word_i.write_data[2:0], freq_q[7:0]},
                                           nr10_q[2:0], nr10_q[3]);
  assign tick_next  = acrs_pkg::sweep_next(swp_q, nr10_q[2:0], nr10_q[3]);
  assign scd_dec    = (scd_q != 4'd0) ? scd_q - 4'd1 : 4'd0;

  // Reply decode: read source and mask, and the unmapped flag for reads and writes.
  always_comb begin
    use_mem_d = 1'b0;
    mask_d    = acrs_pkg::MaskNone;
    const_d   = 8'h00;
    unm_d     = 1'b0;
    case (in_word_i.action)
      acrs_pkg::ActRead: begin
        if (in_word_i.reg_addr inside {acrs_pkg::AddrNr10, acrs_pkg::AddrNr12,
            acrs_pkg::AddrNr22, acrs_pkg::AddrNr30, acrs_pkg::AddrNr32,
            acrs_pkg::AddrNr42, acrs_pkg::AddrNr43, acrs_pkg::AddrNr50,
            acrs_pkg::AddrNr51}) begin
          use_mem_d = 1'b1;
        end else if (in_word_i.reg_addr inside {acrs_pkg::AddrNr11,
                     acrs_pkg::AddrNr21}) begin
          use_mem_d = 1'b1;
          mask_d    = acrs_pkg::MaskDuty;
        end else if (in_word_i.reg_addr inside {acrs_pkg::AddrNr14,
                     acrs_pkg::AddrNr24, acrs_pkg::AddrNr34,
                     acrs_pkg::AddrNr44}) begin
          use_mem_d = 1'b1;
          mask_d    = acrs_pkg::MaskCtrl;
        end else if (in_word_i.reg_addr == acrs_pkg::AddrNr52) begin
          const_d = {power_q, 3'b111, ch_q};
        end else if (in_word_i.reg_addr inside {acrs_pkg::AddrNr13,
                     acrs_pkg::AddrNr23, acrs_pkg::AddrNr31,
                     acrs_pkg::AddrNr33, acrs_pkg::AddrNr41}) begin
          const_d = acrs_pkg::ReadOpen;
        end else begin
          const_d = acrs_pkg::ReadOpen;
          unm_d   = 1'b1;
        end
      end
      acrs_pkg::ActWrite: begin
        unm_d = !(in_word_i.reg_addr inside {[acrs_pkg::AddrNr10:acrs_pkg::AddrNr14],
                  [acrs_pkg::AddrNr21:acrs_pkg::AddrNr34],
                  [acrs_pkg::AddrNr41:acrs_pkg::AddrNr52]});
      end
      default: begin
        unm_d = 1'b0;
      end
    endcase
  end

  // Control state update.
  always_comb begin
    nr10_d   = nr10_q;
    nrx2_d   = nrx2_q;
    len_en_d = len_en_q;
    freq_d   = freq_q;
    power_d  = power_q;
    ch_d     = ch_q;
    len_d    = len_q;
    lenw_d   = lenw_q;
    vol_d    = vol_q;
    ecd_d    = ecd_q;
    swp_d    = swp_q;
    scd_d    = scd_q;
    sact_d   = sact_q;
    seq_d    = seq_q;
    prev_d   = prev_q;
    trig     = 4'b0000;
    mem_we   = 1'b0;
    mem_wdata = in_word_i.write_data;
    ecd_dec  = 3'd0;

    if (accept && in_word_i.action == acrs_pkg::ActWrite && !unm_d) begin
      mem_we = (in_word_i.reg_addr != acrs_pkg::AddrNr52);
      case (in_word_i.reg_addr)
        acrs_pkg::AddrNr10: begin
          mem_wdata = in_word_i.write_data | acrs_pkg::MaskSwp;
          nr10_d    = in_word_i.write_data[6:0];
        end
        acrs_pkg::AddrNr11: begin
          len_d[0] = 7'd64 - {1'b0, in_word_i.write_data[5:0]};
        end
        acrs_pkg::AddrNr12: nrx2_d[0] = in_word_i.write_data;
        acrs_pkg::AddrNr13: freq_d[7:0] = in_word_i.write_data;
        acrs_pkg::AddrNr14: begin
          mem_wdata   = in_word_i.write_data | acrs_pkg::MaskTrig;
          freq_d[10:8] = in_word_i.write_data[2:0];
          len_en_d[0] = in_word_i.write_data[6];
          trig[0]     = in_word_i.write_data[7];
        end
        acrs_pkg::AddrNr21: begin
          len_d[1] = 7'd64 - {1'b0, in_word_i.write_data[5:0]};
        end
        acrs_pkg::AddrNr22: nrx2_d[1] = in_word_i.write_data;
        acrs_pkg::AddrNr24: begin
          mem_wdata   = in_word_i.write_data | acrs_pkg::MaskTrig;
          len_en_d[1] = in_word_i.write_data[6];
          trig[1]     = in_word_i.write_data[7];
        end
        acrs_pkg::AddrNr30: mem_wdata = in_word_i.write_data | acrs_pkg::MaskDac;
        acrs_pkg::AddrNr31: lenw_d = 9'd256 - {1'b0, in_word_i.write_data};
        acrs_pkg::AddrNr32: mem_wdata = in_word_i.write_data | acrs_pkg::MaskLevel;
        acrs_pkg::AddrNr34: begin
          mem_wdata   = in_word_i.write_data | acrs_pkg::MaskTrig;
          len_en_d[2] = in_word_i.write_data[6];
          trig[2]     = in_word_i.write_data[7];
        end
        acrs_pkg::AddrNr41: begin
          mem_wdata = in_word_i.write_data | acrs_pkg::MaskLen4;
          len_d[2]  = 7'd64 - {1'b0, in_word_i.write_data[5:0]};
        end
        acrs_pkg::AddrNr42: nrx2_d[2] = in_word_i.write_data;
        acrs_pkg::AddrNr44: begin
          mem_wdata   = in_word_i.write_data | acrs_pkg::MaskDuty;
          len_en_d[3] = in_word_i.write_data[6];
          trig[3]     = in_word_i.write_data[7];
        end
        acrs_pkg::AddrNr52: begin
          power_d = in_word_i.write_data[7];
          if (!in_word_i.write_data[7]) begin
            ch_d = 4'b0000;
          end
        end
        default: begin
          mem_we = mem_we;
        end
      endcase
    end

    // Triggers.
    ch_d = ch_d | trig;
    if (trig[2] && lenw_q == 9'd0) begin
      lenw_d = 9'd256;
    end
    for (int k = 0; k < 3; k++) begin
      if (trig[(k == 2) ? 3 : k]) begin
        if (len_q[k] == 7'd0) begin
          len_d[k] = 7'd64;
        end
        vol_d[k] = nrx2_q[k][7:4];
        ecd_d[k] = nrx2_q[k][2:0];
      end
    end
    if (trig[0]) begin
      swp_d  = freq_d;
      scd_d  = pace_reload;
      sact_d = (nr10_q[6:4] != 3'd0) || (nr10_q[2:0] != 3'd0);
      if (nr10_q[2:0] != 3'd0 && trig_next[11]) begin
        ch_d[0] = 1'b0;
      end
    end

    // Frame sequencer.
    if (accept && in_word_i.action == acrs_pkg::ActTick) begin
      prev_d = in_word_i.div_value[4];
      if (prev_q && !in_word_i.div_value[4]) begin
        seq_d = seq_q + 3'd1;
        if (!seq_q[0]) begin
          for (int k = 0; k < 3; k++) begin
            if (len_en_q[(k == 2) ? 3 : k] && len_q[k] != 7'd0) begin
              len_d[k] = len_q[k] - 7'd1;
              if (len_q[k] == 7'd1) begin
                ch_d[(k == 2) ? 3 : k] = 1'b0;
              end
            end
          end
          if (len_en_q[2] && lenw_q != 9'd0) begin
            lenw_d = lenw_q - 9'd1;
            if (lenw_q == 9'd1) begin
              ch_d[2] = 1'b0;
            end
          end
        end
        if (seq_q[1:0] == 2'b10) begin
          if (scd_dec != 4'd0) begin
            scd_d = scd_dec;
          end else begin
            scd_d = pace_reload;
            if (sact_q && nr10_q[6:4] != 3'd0) begin
              if (tick_next[11]) begin
                ch_d[0] = 1'b0;
              end else if (nr10_q[2:0] != 3'd0) begin
                swp_d  = tick_next[10:0];
                freq_d = tick_next[10:0];
              end
            end
          end
        end
        if (seq_q == 3'd7) begin
          for (int k = 0; k < 3; k++) begin
            if (nrx2_q[k][2:0] != 3'd0) begin
              ecd_dec = (ecd_q[k] != 3'd0) ? ecd_q[k] - 3'd1 : 3'd0;
              if (ecd_dec != 3'd0) begin
                ecd_d[k] = ecd_dec;
              end else begin
                ecd_d[k] = nrx2_q[k][2:0];
                if (nrx2_q[k][3]) begin
                  if (vol_q[k] != 4'd15) vol_d[k] = vol_q[k] + 4'd1;
                end else if (vol_q[k] != 4'd0) begin
                  vol_d[k] = vol_q[k] - 4'd1;
                end
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nr10_q   <= 7'h00;
      nrx2_q   <= '{8'hF3, 8'h00, 8'h00};
      len_en_q <= 4'b0000;
      freq_q   <= acrs_pkg::PeriodMax;
      power_q  <= 1'b1;
      ch_q     <= 4'b0001;
      len_q    <= '{7'd0, 7'd0, 7'd0};
      lenw_q   <= 9'd0;
      vol_q    <= '{4'd0, 4'd0, 4'd0};
      ecd_q    <= '{3'd0, 3'd0, 3'd0};
      swp_q    <= 11'd0;
      scd_q    <= 4'd0;
      sact_q   <= 1'b0;
      seq_q    <= 3'd0;
      prev_q   <= 1'b0;
      mvld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      nr10_q   <= nr10_d;
      nrx2_q   <= nrx2_d;
      len_en_q <= len_en_d;
      freq_q   <= freq_d;
      power_q  <= power_d;
      ch_q     <= ch_d;
      len_q    <= len_d;
      lenw_q   <= lenw_d;
      vol_q    <= vol_d;
      ecd_q    <= ecd_d;
      swp_q    <= swp_d;
      scd_q    <= scd_d;
      sact_q   <= sact_d;
      seq_q    <= seq_d;
      prev_q   <= prev_d;
      if (mem_we) begin
        mvld_q[idx] <= 1'b1;
      end
      out_valid_q <= accept | (out_valid_q & out_stall_i);
    end
  end

  // Register memory and result stage.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[idx] <= mem_wdata;
    end
    if (accept) begin
      mdata_q   <= mem_q[idx];
      mdvld_q   <= mvld_q[idx];
      use_mem_q <= use_mem_d;
      mask_q    <= mask_d;
      const_q   <= const_d;
      idx_q     <= idx;
      unm_q     <= unm_d;
      chout_q   <= ch_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o.read_data = use_mem_q
      ? ((mdvld_q ? mdata_q : acrs_pkg::reg_init(idx_q)) | mask_q) : const_q;
  assign out_word_o.unmapped    = unm_q;
  assign out_word_o.channels_on = chout_q;

`ifndef ASSERT_OFF
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q) else $error("accepted word produced no result");

  a_power_off_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_word_i.action == acrs_pkg::ActWrite &&
    in_word_i.reg_addr == acrs_pkg::AddrNr52 && !in_word_i.write_data[7]
    |=> ch_q == 4'b0000 && !power_q) else $error("power off left channels on");

  a_seq_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(accept && in_word_i.action == acrs_pkg::ActTick) |=> $stable(seq_q))
    else $error("sequencer moved without a tick");

  a_wave_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lenw_q <= 9'd256) else $error("wave length counter out of range");
`endif

endmodule
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: scoreboard bench for the sound control registers and sequencer
// Sends register reads, register writes and divider ticks through the input
// channel in random bursts. A cycle-free model of the register file, frame
// sequencer, length counters, channel-1 sweep and envelopes predicts every
// reply word. The monitor checks each reply field by field, in order, while
// the receiver stalls on its own pattern, with one long hold-off among them.
// ----------------------------------------------------------------------------
module tb_top;
  import acrs_pkg::*;

  localparam int NumRandomOps  = 1650;
  localparam int CycleLimit    = 200000;
  localparam int HoldOffAfter  = 400;
  localparam int HoldOffCycles = 400;

  localparam logic [7:0] AddrLowest  = 8'h00;
  localparam logic [7:0] AddrHighest = 8'hFF;
  localparam logic [7:0] AddrHole1   = 8'h15;
  localparam logic [7:0] AddrHole2   = 8'h1F;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  audio_control_registers_and_sequencer_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Model state
  logic [7:0]  sreg [8'h10:8'h26];
  logic [2:0]  frame_step;
  logic        div_bit_prev;
  logic [6:0]  len_left [3];
  logic [8:0]  wave_len_left;
  logic [3:0]  env_vol [3];
  logic [2:0]  env_wait [3];
  logic [10:0] sweep_freq;
  logic [3:0]  sweep_wait;
  logic        sweep_en;

  in_word_t  bus_ops [$];
  out_word_t due_replies [$];
  out_word_t head_reply;

  logic word_taken  = 1'b0;
  logic hold_off    = 1'b0;
  int   ops_taken   = 0;
  int   cycle_count = 0;
  int   errors      = 0;
  int   burst_left  = 1;
  int   gap_left    = 0;
  int   stall_mode  = 0;
  int   stall_left  = 0;
  int   stall_phase = 0;

  function automatic logic [11:0] sweep_target(input logic [2:0] shift);
    logic [11:0] delta;
    delta = {1'b0, sweep_freq >> shift};
    return sreg[AddrNr10][3] ? ({1'b0, sweep_freq} - delta) : ({1'b0, sweep_freq} + delta);
  endfunction

  function automatic void fire_channel(input int ch);
    logic [7:0] envr;
    logic [2:0] pace;
    logic [2:0] shift;
    int         k;
    sreg[AddrNr52][ch] = 1'b1;
    if (ch == 2) begin
      if (wave_len_left == 0) wave_len_left = 9'd256;
      return;
    end
    k    = (ch == 3) ? 2 : ch;
    envr = (ch == 0) ? sreg[AddrNr12] : ((ch == 1) ? sreg[AddrNr22] : sreg[AddrNr42]);
    if (len_left[k] == 0) len_left[k] = 7'd64;
    env_vol[k]  = envr[7:4];
    env_wait[k] = envr[2:0];
    if (ch == 0) begin
      pace       = sreg[AddrNr10][6:4];
      shift      = sreg[AddrNr10][2:0];
      sweep_freq = {sreg[AddrNr14][2:0], sreg[AddrNr13]};
      sweep_wait = (pace != 0) ? {1'b0, pace} : 4'd8;
      sweep_en   = (pace != 0) || (shift != 0);
      if (shift != 0 && sweep_target(shift) > {1'b0, PeriodMax}) sreg[AddrNr52][0] = 1'b0;
    end
  endfunction

  function automatic void clock_length(input int k, input logic [7:0] ctl, input int ch);
    if (!ctl[6] || len_left[k] == 0) return;
    len_left[k] = len_left[k] - 7'd1;
    if (len_left[k] == 0) sreg[AddrNr52][ch] = 1'b0;
  endfunction

  function automatic void clock_envelope(input int k, input logic [7:0] envr);
    if (envr[2:0] == 0) return;
    if (env_wait[k] != 0) env_wait[k] = env_wait[k] - 3'd1;
    if (env_wait[k] != 0) return;
    env_wait[k] = envr[2:0];
    if (envr[3]) begin
      if (env_vol[k] != 4'hF) env_vol[k] = env_vol[k] + 4'd1;
    end else if (env_vol[k] != 0) begin
      env_vol[k] = env_vol[k] - 4'd1;
    end
  endfunction

  function automatic out_word_t predict_reply(input in_word_t w);
    out_word_t   r;
    logic [7:0]  v;
    logic [2:0]  pace;
    logic [2:0]  shift;
    logic [11:0] nxt;
    r = '0;
    v = w.write_data;
    case (w.action)
      ActRead: begin
        case (w.reg_addr)
          AddrNr10, AddrNr12, AddrNr22, AddrNr30, AddrNr32, AddrNr42, AddrNr43,
          AddrNr50, AddrNr51, AddrNr52:
            r.read_data = sreg[w.reg_addr];
          AddrNr11, AddrNr21:
            r.read_data = sreg[w.reg_addr] | MaskDuty;
          AddrNr14, AddrNr24, AddrNr34, AddrNr44:
            r.read_data = sreg[w.reg_addr] | MaskCtrl;
          AddrNr13, AddrNr23, AddrNr31, AddrNr33, AddrNr41:
            r.read_data = ReadOpen;
          default: begin
            r.read_data = ReadOpen;
            r.unmapped  = 1'b1;
          end
        endcase
      end
      ActWrite: begin
        case (w.reg_addr)
          AddrNr10: sreg[AddrNr10] = v | MaskSwp;
          AddrNr11: begin
            sreg[AddrNr11] = v;
            len_left[0]    = 7'd64 - {1'b0, v[5:0]};
          end
          AddrNr12, AddrNr13, AddrNr22, AddrNr23, AddrNr33, AddrNr42, AddrNr43,
          AddrNr50, AddrNr51:
            sreg[w.reg_addr] = v;
          AddrNr14: begin
            sreg[AddrNr14] = v | MaskTrig;
            if (v[7]) fire_channel(0);
          end
          AddrNr21: begin
            sreg[AddrNr21] = v;
            len_left[1]    = 7'd64 - {1'b0, v[5:0]};
          end
          AddrNr24: begin
            sreg[AddrNr24] = v | MaskTrig;
            if (v[7]) fire_channel(1);
          end
          AddrNr30: sreg[AddrNr30] = v | MaskDac;
          AddrNr31: begin
            sreg[AddrNr31] = v;
            wave_len_left  = 9'd256 - {1'b0, v};
          end
          AddrNr32: sreg[AddrNr32] = v | MaskLevel;
          AddrNr34: begin
            sreg[AddrNr34] = v | MaskTrig;
            if (v[7]) fire_channel(2);
          end
          AddrNr41: begin
            sreg[AddrNr41] = v | MaskLen4;
            len_left[2]    = 7'd64 - {1'b0, v[5:0]};
          end
          AddrNr44: begin
            sreg[AddrNr44] = v | MaskDuty;
            if (v[7]) fire_channel(3);
          end
          AddrNr52:
            sreg[AddrNr52] = v[7] ? {4'hF, sreg[AddrNr52][3:0]} : 8'h70;
          default: r.unmapped = 1'b1;
        endcase
      end
      ActTick: begin
        if (div_bit_prev && !w.div_value[4]) begin
          if (!frame_step[0]) begin
            clock_length(0, sreg[AddrNr14], 0);
            clock_length(1, sreg[AddrNr24], 1);
            if (sreg[AddrNr34][6] && wave_len_left != 0) begin
              wave_len_left = wave_len_left - 9'd1;
              if (wave_len_left == 0) sreg[AddrNr52][2] = 1'b0;
            end
            clock_length(2, sreg[AddrNr44], 3);
          end
          if (frame_step == 3'd2 || frame_step == 3'd6) begin
            if (sweep_wait != 0) sweep_wait = sweep_wait - 4'd1;
            if (sweep_wait == 0) begin
              pace       = sreg[AddrNr10][6:4];
              sweep_wait = (pace != 0) ? {1'b0, pace} : 4'd8;
              if (sweep_en && pace != 0) begin
                shift = sreg[AddrNr10][2:0];
                nxt   = sweep_target(shift);
                if (nxt > {1'b0, PeriodMax}) begin
                  sreg[AddrNr52][0] = 1'b0;
                end else if (shift != 0) begin
                  sweep_freq          = nxt[10:0];
                  sreg[AddrNr13]      = nxt[7:0];
                  sreg[AddrNr14][2:0] = nxt[10:8];
                end
              end
            end
          end
          if (frame_step == 3'd7) begin
            clock_envelope(0, sreg[AddrNr12]);
            clock_envelope(1, sreg[AddrNr22]);
            clock_envelope(2, sreg[AddrNr42]);
          end
          frame_step = frame_step + 3'd1;
        end
        div_bit_prev = w.div_value[4];
      end
      default: ;
    endcase
    r.channels_on = sreg[AddrNr52][3:0];
    return r;
  endfunction

  function automatic void push_op(input action_e act, input logic [7:0] addr,
                                  input logic [7:0] data, input logic [7:0] div);
    in_word_t w;
    w.action     = act;
    w.reg_addr   = addr;
    w.write_data = data;
    w.div_value  = div;
    bus_ops.push_back(w);
  endfunction

  function automatic logic [7:0] mapped_addr(input int i);
    case (i)
      0:       return AddrNr10;
      1:       return AddrNr11;
      2:       return AddrNr12;
      3:       return AddrNr13;
      4:       return AddrNr14;
      5:       return AddrNr21;
      6:       return AddrNr22;
      7:       return AddrNr23;
      8:       return AddrNr24;
      9:       return AddrNr30;
      10:      return AddrNr31;
      11:      return AddrNr32;
      12:      return AddrNr33;
      13:      return AddrNr34;
      14:      return AddrNr41;
      15:      return AddrNr42;
      16:      return AddrNr43;
      17:      return AddrNr44;
      18:      return AddrNr50;
      19:      return AddrNr51;
      default: return AddrNr52;
    endcase
  endfunction

  // Driver: offer words in bursts, hold each one until taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || word_taken)) begin
      if (gap_left > 0 || bus_ops.size() == 0) begin
        in_valid_i <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        in_word_i  <= bus_ops.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Receiver: stall pattern picked at random from four modes, renewed when its counter runs out
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_phase <= stall_phase + 1;
    case (stall_mode)
      0:       out_stall_i <= hold_off;
      1:       out_stall_i <= hold_off || ($urandom_range(0, 1) == 0);
      2:       out_stall_i <= hold_off || ((stall_phase % 5) < 2);
      default: out_stall_i <= hold_off || ($urandom_range(0, 7) == 0);
    endcase
  end

  // Hold off the receiver once so the block backs up into its input
  initial begin
    while (ops_taken < HoldOffAfter) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HoldOffCycles) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Monitor: check replies, predict on every accepted word
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    word_taken  = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (due_replies.size() == 0) begin
          $display("%0t: reply %h with nothing due", $time, out_word_o);
          errors++;
        end else begin
          head_reply = due_replies.pop_front();
          if (out_word_o.read_data !== head_reply.read_data) begin
            $display("%0t: read_data expected %h actual %h", $time,
                     head_reply.read_data, out_word_o.read_data);
            errors++;
          end
          if (out_word_o.unmapped !== head_reply.unmapped) begin
            $display("%0t: unmapped expected %b actual %b", $time,
                     head_reply.unmapped, out_word_o.unmapped);
            errors++;
          end
          if (out_word_o.channels_on !== head_reply.channels_on) begin
            $display("%0t: channels_on expected %h actual %h", $time,
                     head_reply.channels_on, out_word_o.channels_on);
            errors++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        due_replies.push_back(predict_reply(in_word_i));
        word_taken = 1'b1;
        ops_taken++;
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int         sel;
    int         idx;
    logic [7:0] a;
    logic [7:0] d;
    logic       tick_bit;

    for (int i = 8'h10; i <= 8'h26; i++) sreg[i] = 8'hFF;
    sreg[AddrNr10] = 8'h80;  sreg[AddrNr11] = 8'hBF;  sreg[AddrNr12] = 8'hF3;
    sreg[AddrNr14] = 8'hBF;  sreg[AddrNr21] = 8'h3F;  sreg[AddrNr22] = 8'h00;
    sreg[AddrNr24] = 8'hBF;  sreg[AddrNr30] = 8'h7F;  sreg[AddrNr32] = 8'h9F;
    sreg[AddrNr34] = 8'hBF;  sreg[AddrNr42] = 8'h00;  sreg[AddrNr43] = 8'h00;
    sreg[AddrNr44] = 8'hBF;  sreg[AddrNr50] = 8'h77;  sreg[AddrNr51] = 8'hF3;
    sreg[AddrNr52] = 8'hF1;
    frame_step    = '0;
    div_bit_prev  = 1'b0;
    wave_len_left = '0;
    sweep_freq    = '0;
    sweep_wait    = '0;
    sweep_en      = 1'b0;
    for (int k = 0; k < 3; k++) begin
      len_left[k] = '0;
      env_vol[k]  = '0;
      env_wait[k] = '0;
    end
    tick_bit = 1'b0;

    // Unhandled and write-only addresses
    push_op(ActRead, AddrNr52, 8'h00, 8'h00);
    push_op(ActRead, AddrLowest, 8'h00, 8'h00);
    push_op(ActRead, AddrHighest, 8'hFF, 8'hFF);
    push_op(ActRead, AddrHole1, 8'h00, 8'h00);
    push_op(ActRead, AddrHole2, 8'h00, 8'h00);
    push_op(ActWrite, AddrHighest, 8'hFF, 8'h00);
    push_op(ActWrite, AddrNr13, 8'hFF, 8'h00);
    push_op(ActRead, AddrNr13, 8'h00, 8'h00);
    // Sweep overflow on trigger, then a trigger that stays on
    push_op(ActWrite, AddrNr10, 8'h11, 8'h00);
    push_op(ActWrite, AddrNr14, 8'h87, 8'h00);
    push_op(ActWrite, AddrNr14, 8'hC0, 8'h00);
    push_op(ActRead, AddrNr14, 8'h00, 8'h00);
    // Power off, trigger while off, power on
    push_op(ActWrite, AddrNr52, 8'h00, 8'h00);
    push_op(ActRead, AddrNr52, 8'h00, 8'h00);
    push_op(ActWrite, AddrNr24, 8'h80, 8'h00);
    push_op(ActRead, AddrNr52, 8'h00, 8'h00);
    push_op(ActWrite, AddrNr52, 8'hFF, 8'h00);
    push_op(ActRead, AddrNr52, 8'h00, 8'h00);
    push_op(ActIgnore, AddrHighest, 8'hFF, 8'hFF);
    // Divider edges, extremes of the tick value
    push_op(ActTick, 8'h00, 8'h00, 8'hFF);
    push_op(ActTick, 8'h00, 8'h00, 8'h00);
    push_op(ActTick, 8'hFF, 8'hFF, 8'h10);
    push_op(ActTick, 8'h00, 8'h00, 8'hEF);
    push_op(ActWrite, AddrNr11, 8'h00, 8'h00);

    for (int n = 0; n < NumRandomOps; n++) begin
      sel = $urandom_range(0, 99);
      d   = 8'($urandom_range(0, 255));
      if (sel < 38) begin
        if ($urandom_range(0, 3) != 0) tick_bit = !tick_bit;
        d[4] = tick_bit;
        push_op(ActTick, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), d);
      end else if (sel < 73) begin
        idx = $urandom_range(0, 20);
        a   = mapped_addr(idx);
        case (a)
          AddrNr11, AddrNr21, AddrNr41:
            if ($urandom_range(0, 1) == 0) d[5:3] = 3'b111;
          AddrNr31:
            if ($urandom_range(0, 1) == 0) d[7:4] = 4'hF;
          AddrNr14, AddrNr24, AddrNr34, AddrNr44:
            if ($urandom_range(0, 2) != 0) d[6] = 1'b1;
          AddrNr52:
            if ($urandom_range(0, 3) != 0) d[7] = 1'b1;
          default: ;
        endcase
        push_op(ActWrite, a, d, 8'($urandom_range(0, 255)));
      end else if (sel < 90) begin
        idx = $urandom_range(0, 20);
        push_op(ActRead, mapped_addr(idx), d, 8'($urandom_range(0, 255)));
      end else if (sel < 97) begin
        push_op(action_e'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), d,
                8'($urandom_range(0, 255)));
      end else begin
        push_op(ActIgnore, 8'($urandom_range(0, 255)), d, 8'($urandom_range(0, 255)));
      end
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (bus_ops.size() != 0 || in_valid_i || due_replies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: audio_control_registers_and_sequencer_top.f
rtl/core/acrs_pkg.sv
rtl/core/audio_control_registers_and_sequencer_top.sv
dv/tb_top.sv
